>>> hdl/assert_macros.svh
// Assertion helpers used by the RTL (the tag array includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_PROP(lbl, clk, rst, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> hdl/lkv_pkg.sv
package lkv_pkg;

  localparam int LKV_ENTRIES    = 16;
  localparam int LKV_KEY_BITS   = 32;
  localparam int LKV_VALUE_BITS = 32;
  localparam int CAP_BITS       = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } state_t;

  // outcome of the lookup, handed from the tag array to the control
  typedef struct packed {
    logic op;
    logic hit;
    logic evict;
    logic ins;
  } lkv_flags_t;

endpackage

>>> hdl/lkv_req_if.sv
interface lkv_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, opcode, lookup_key, write_value, input ready);
  modport sink   (input valid, opcode, lookup_key, write_value, output ready);
endinterface

>>> hdl/lkv_rsp_if.sv
interface lkv_rsp_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;
  logic [VALUE_BITS-1:0] evicted_value;

  modport source (output valid, status, read_value, evicted, evicted_key, evicted_value,
                  input ready);
  modport sink   (input valid, status, read_value, evicted, evicted_key, evicted_value,
                  output ready);
endinterface

>>> hdl/lkv_value_ram.sv
module lkv_value_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/lkv_tag_array.sv
`include "assert_macros.svh"
module lkv_tag_array import lkv_pkg::*; #(
  parameter int ENTRIES  = LKV_ENTRIES,
  parameter int KEY_BITS = LKV_KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       capture,
  input  logic                       op,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [$clog2(ENTRIES):0]   cap,
  output lkv_flags_t                 flags,
  output logic [$clog2(ENTRIES)-1:0] rd_idx,
  output logic [$clog2(ENTRIES)-1:0] wr_idx,
  output logic [KEY_BITS-1:0]        evicted_key
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  logic [KEY_BITS-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0]  valid;
  logic [IDX_W-1:0]    rank [ENTRIES];
  logic [CNT_W-1:0]    count;

  logic             hit, evict, ins;
  logic [IDX_W-1:0] hit_idx, ev_idx, free_idx, hit_rank, last_rank;
  logic [IDX_W-1:0] tr [ENTRIES];
  logic [IDX_W-1:0] rank_next [ENTRIES];
  logic [ENTRIES-1:0] valid_next;
  logic [CNT_W-1:0] count_next;

  // parallel key compare
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit_rank  = rank[hit_idx];
  assign last_rank = IDX_W'(count - 1'b1);
  assign evict     = (op == OP_SET) && (hit ? (count > cap) : (count >= cap));
  assign ins       = (op == OP_SET) && !hit;

  // ranks after the hit entry moves to the front
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      tr[i] = rank[i];
      if (hit) begin
        if (IDX_W'(i) == hit_idx) begin
          tr[i] = '0;
        end else if (rank[i] < hit_rank) begin
          tr[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // oldest entry holds rank count-1; free slot is the lowest empty or evicted one
  always_comb begin
    ev_idx   = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid[i] && tr[i] == last_rank) begin
        ev_idx = IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i] || (evict && IDX_W'(i) == ev_idx)) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = tr[i];
    end
    if (evict) begin
      valid_next[ev_idx] = 1'b0;
      rank_next[ev_idx]  = '0;
      count_next         = count_next - 1'b1;
    end
    if (ins) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_next[i]) begin
          rank_next[i] = rank_next[i] + 1'b1;
        end
      end
      valid_next[free_idx] = 1'b1;
      rank_next[free_idx]  = '0;
      count_next           = count_next + 1'b1;
    end
  end

  assign rd_idx = (op == OP_GET) ? hit_idx : ev_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      flags <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (capture) begin
      valid <= valid_next;
      count <= count_next;
      flags <= '{op: op, hit: hit, evict: evict, ins: ins};
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      if (ins) begin
        keys[free_idx] <= key;
      end
      wr_idx      <= ins ? free_idx : hit_idx;
      evicted_key <= keys[ev_idx];
    end
  end

  `ASSERT_PROP(a_count_matches, clk, rst, $countones(valid) == 32'(count))
  `ASSERT_NEVER(a_count_range, clk, rst, count > CNT_W'(ENTRIES))
  `ASSERT_PROP(a_evict_valid, clk, rst, (capture && evict) |-> valid[ev_idx])

endmodule

>>> hdl/lru_key_value_cache_top.sv
// Channel  | Dir | Payload                                                   | Handshake
// req      | in  | opcode, lookup_key, write_value                           | valid/ready
// rsp      | out | status, read_value, evicted, evicted_key, evicted_value   | valid/ready
// cfg      | in  | cfg_wr_data (capacity_limit)                              | cfg_wr_en
//
// Each beat passes through accept (IDLE), key compare/recency update (LOOK),
// then value RAM read data and write back (UPD); the RAM read is registered.
// Reset clears valid bits, ranks and count; no clearing pass is needed.
// rsp is a registered stage: a new req beat is taken while a result waits,
// and only the write-back cycle stalls if rsp is still full.
module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int ENTRIES    = LKV_ENTRIES,
  parameter int KEY_BITS   = LKV_KEY_BITS,
  parameter int VALUE_BITS = LKV_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  lkv_req_if.sink             req,
  lkv_rsp_if.source           rsp,
  input  logic                cfg_wr_en,
  input  logic [CAP_BITS-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  state_t state, state_next;

  logic [CAP_BITS-1:0]   capacity_limit;
  logic [CW-1:0]         cap_x;
  logic [CNT_W-1:0]      cap_eff;

  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  lkv_flags_t            flags;
  logic [IDX_W-1:0]      rd_idx, wr_idx;
  logic [KEY_BITS-1:0]   ev_key;
  logic [VALUE_BITS-1:0] rd_data;
  logic                  load;

  logic                  out_valid;
  logic                  out_status, out_evicted;
  logic [VALUE_BITS-1:0] out_read, out_ev_value;
  logic [KEY_BITS-1:0]   out_ev_key;

  // capacity register; 0 acts as 1, values above the store size saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity_limit <= cfg_wr_data;
    end
  end

  assign cap_x   = CW'(capacity_limit);
  assign cap_eff = (capacity_limit == '0) ? CNT_W'(1) :
                   (cap_x > CW'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(cap_x);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold here until the output stage has room
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q  <= req.opcode;
      key_q <= req.lookup_key;
      val_q <= req.write_value;
    end
  end

  lkv_tag_array #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_tags (
    .clk         (clk),
    .rst         (rst),
    .capture     (state == ST_LOOK),
    .op          (op_q),
    .key         (key_q),
    .cap         (cap_eff),
    .flags       (flags),
    .rd_idx      (rd_idx),
    .wr_idx      (wr_idx),
    .evicted_key (ev_key)
  );

  // read in the compare cycle (hit value or victim value), write back after
  lkv_value_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_values (
    .clk     (clk),
    .rd_en   (state == ST_LOOK),
    .rd_addr (rd_idx),
    .rd_data (rd_data),
    .wr_en   (load && flags.op == OP_SET),
    .wr_addr (wr_idx),
    .wr_data (val_q)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status   <= (flags.op == OP_GET && !flags.hit) ? STATUS_MISS : STATUS_OK;
      out_read     <= (flags.op == OP_GET && flags.hit) ? rd_data : '0;
      out_evicted  <= flags.evict;
      out_ev_key   <= flags.evict ? ev_key : '0;
      out_ev_value <= flags.evict ? rd_data : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.read_value    = out_read;
  assign rsp.evicted       = out_evicted;
  assign rsp.evicted_key   = out_ev_key;
  assign rsp.evicted_value = out_ev_value;

endmodule
